>>> hw/rtl/slp_pkg.sv
`timescale 1ns / 1ps

package slp_pkg;

    // Default width of the integer-part accumulator
    localparam int ACC_WIDTH_DEFAULT = 32;

    // ASCII codes the parser reacts to
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Number of fields completed so far in the line
    localparam logic [1:0] FIELD_PRESSURE = 2'd0;
    localparam logic [1:0] FIELD_HEIGHT   = 2'd1;
    localparam logic [1:0] FIELD_DONE     = 2'd2;

    // Saturation limits of the result fields
    localparam logic [31:0] PRESSURE_MAX   = 32'hFFFF_FFFF;
    localparam logic [31:0] HEIGHT_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] HEIGHT_NEG_MAG = 32'h8000_0000;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_line;
    } item_t;

    typedef struct packed {
        logic [31:0]        pressure_tenths;
        logic signed [31:0] height_tenths;
        logic               parse_ok;
    } result_t;

endpackage

>>> hw/rtl/slp_mul10_sat.sv
`timescale 1ns / 1ps

// value * 10 + digit, saturating at the all-ones value of ACC_WIDTH bits
module slp_mul10_sat #(
    parameter int ACC_WIDTH = slp_pkg::ACC_WIDTH_DEFAULT
) (
    input  logic [ACC_WIDTH-1:0] value,
    input  logic [3:0]           digit,
    output logic [ACC_WIDTH-1:0] result
);

    localparam int WIDE_W = ACC_WIDTH + 4;

    logic [WIDE_W-1:0] value_wide;
    logic [WIDE_W-1:0] sum_wide;

    assign value_wide = {4'd0, value};
    // x*10 = x*8 + x*2
    assign sum_wide = (value_wide << 3) + (value_wide << 1)
                    + {{ACC_WIDTH{1'b0}}, digit};

    assign result = (|sum_wide[WIDE_W-1:ACC_WIDTH]) ? {ACC_WIDTH{1'b1}}
                                                    : sum_wide[ACC_WIDTH-1:0];

endmodule

>>> hw/rtl/slp_parser_core.sv
`timescale 1ns / 1ps

// Per-byte line state and the step logic; emits one result on the last byte
module slp_parser_core #(
    parameter int ACC_WIDTH = slp_pkg::ACC_WIDTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  slp_pkg::item_t  item,
    output logic            result_valid,
    output slp_pkg::result_t result
);

    localparam int EXT_W = (ACC_WIDTH > 33) ? ACC_WIDTH : 33;

    localparam logic [EXT_W-1:0] PRESSURE_MAX_EXT   = EXT_W'(slp_pkg::PRESSURE_MAX);
    localparam logic [EXT_W-1:0] HEIGHT_POS_MAX_EXT = EXT_W'(slp_pkg::HEIGHT_POS_MAX);
    localparam logic [EXT_W-1:0] HEIGHT_NEG_MAG_EXT = EXT_W'(slp_pkg::HEIGHT_NEG_MAG);

    logic [ACC_WIDTH-1:0] accumulator_reg, accumulator_next;
    logic [1:0]           field_index_reg, field_index_next;
    logic                 negative_sign_reg, negative_sign_next;
    logic                 token_start_reg, token_start_next;
    logic                 fraction_pending_reg, fraction_pending_next;
    logic                 token_bad_reg, token_bad_next;
    logic [31:0]          saved_pressure_reg, saved_pressure_next;
    logic [31:0]          saved_height_reg, saved_height_next;
    logic                 format_good_reg, format_good_next;

    logic [7:0]           rx;
    logic                 is_digit;
    logic [3:0]           digit_val;
    logic [ACC_WIDTH-1:0] acc_mac;
    logic [EXT_W-1:0]     acc_ext;
    logic [31:0]          pressure_sat;
    logic [31:0]          height_sat;
    logic [31:0]          neg_mag;
    logic                 line_ok;

    assign rx        = item.rx_byte;
    assign is_digit  = rx inside {[slp_pkg::CHAR_ZERO:slp_pkg::CHAR_NINE]};
    // '0'..'9' are 0x30..0x39: the low nibble is the digit value
    assign digit_val = is_digit ? rx[3:0] : 4'd0;

    // One shared multiply-add: digit accumulate and number completion
    slp_mul10_sat #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_mul10 (
        .value  (accumulator_reg),
        .digit  (digit_val),
        .result (acc_mac)
    );

    assign acc_ext      = EXT_W'(acc_mac);
    assign pressure_sat = (acc_ext > PRESSURE_MAX_EXT) ? slp_pkg::PRESSURE_MAX
                                                       : acc_ext[31:0];
    assign neg_mag      = (acc_ext > HEIGHT_NEG_MAG_EXT) ? slp_pkg::HEIGHT_NEG_MAG
                                                         : acc_ext[31:0];
    assign height_sat   = negative_sign_reg ? (32'd0 - neg_mag)
                        : ((acc_ext > HEIGHT_POS_MAX_EXT) ? slp_pkg::HEIGHT_POS_MAX
                                                          : acc_ext[31:0]);

    always_comb
    begin
        accumulator_next      = accumulator_reg;
        field_index_next      = field_index_reg;
        negative_sign_next    = negative_sign_reg;
        token_start_next      = token_start_reg;
        fraction_pending_next = fraction_pending_reg;
        token_bad_next        = token_bad_reg;
        saved_pressure_next   = saved_pressure_reg;
        saved_height_next     = saved_height_reg;
        format_good_next      = format_good_reg;

        if (fraction_pending_reg)
        begin
            // tenths digit closes the number; a non-digit closes it with zero
            if (!is_digit)
                format_good_next = 1'b0;
            if (field_index_reg == slp_pkg::FIELD_PRESSURE)
                saved_pressure_next = pressure_sat;
            else
                saved_height_next = height_sat;
            field_index_next      = field_index_reg + 2'd1;
            fraction_pending_next = 1'b0;
            if (rx == slp_pkg::CHAR_SPACE)
            begin
                accumulator_next   = '0;
                negative_sign_next = 1'b0;
                token_start_next   = 1'b1;
                token_bad_next     = 1'b0;
            end
            else
            begin
                token_bad_next   = 1'b1;
                token_start_next = 1'b0;
            end
        end
        else if (rx == slp_pkg::CHAR_SPACE)
        begin
            accumulator_next   = '0;
            negative_sign_next = 1'b0;
            token_start_next   = 1'b1;
            token_bad_next     = 1'b0;
        end
        else if (rx == slp_pkg::CHAR_DOT)
        begin
            if (field_index_reg != slp_pkg::FIELD_DONE)
            begin
                if (token_bad_reg)
                    format_good_next = 1'b0;
                fraction_pending_next = 1'b1;
            end
            else
                token_bad_next = 1'b1;   // dots after the second number
            token_start_next = 1'b0;
        end
        else if (rx == slp_pkg::CHAR_MINUS && token_start_reg
                 && field_index_reg == slp_pkg::FIELD_HEIGHT)
        begin
            negative_sign_next = 1'b1;
            token_start_next   = 1'b0;
        end
        else if (is_digit)
        begin
            accumulator_next = acc_mac;
            token_start_next = 1'b0;
        end
        else
        begin
            token_bad_next   = 1'b1;
            token_start_next = 1'b0;
        end
    end

    assign line_ok = format_good_next && !fraction_pending_next
                  && (field_index_next == slp_pkg::FIELD_DONE);

    assign result_valid           = accept && item.end_of_line;
    assign result.pressure_tenths = line_ok ? saved_pressure_next : 32'd0;
    assign result.height_tenths   = line_ok ? signed'(saved_height_next) : 32'sd0;
    assign result.parse_ok        = line_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accumulator_reg      <= '0;
            field_index_reg      <= slp_pkg::FIELD_PRESSURE;
            negative_sign_reg    <= 1'b0;
            token_start_reg      <= 1'b1;
            fraction_pending_reg <= 1'b0;
            token_bad_reg        <= 1'b0;
            saved_pressure_reg   <= 32'd0;
            saved_height_reg     <= 32'd0;
            format_good_reg      <= 1'b1;
        end
        else if (accept)
        begin
            if (item.end_of_line)
            begin
                // line done: back to the reset picture
                accumulator_reg      <= '0;
                field_index_reg      <= slp_pkg::FIELD_PRESSURE;
                negative_sign_reg    <= 1'b0;
                token_start_reg      <= 1'b1;
                fraction_pending_reg <= 1'b0;
                token_bad_reg        <= 1'b0;
                saved_pressure_reg   <= 32'd0;
                saved_height_reg     <= 32'd0;
                format_good_reg      <= 1'b1;
            end
            else
            begin
                accumulator_reg      <= accumulator_next;
                field_index_reg      <= field_index_next;
                negative_sign_reg    <= negative_sign_next;
                token_start_reg      <= token_start_next;
                fraction_pending_reg <= fraction_pending_next;
                token_bad_reg        <= token_bad_next;
                saved_pressure_reg   <= saved_pressure_next;
                saved_height_reg     <= saved_height_next;
                format_good_reg      <= format_good_next;
            end
        end
    end

    a_pending_field: assert property (@(posedge clk) disable iff (!rst_n)
        fraction_pending_reg |-> (field_index_reg == slp_pkg::FIELD_PRESSURE
                               || field_index_reg == slp_pkg::FIELD_HEIGHT))
        else $error("tenths digit pending with both fields already done");

    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.end_of_line) |=> (field_index_reg == slp_pkg::FIELD_PRESSURE
                                       && token_start_reg && format_good_reg
                                       && !fraction_pending_reg))
        else $error("line state not cleared after last byte");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.parse_ok) |->
            (result.pressure_tenths == 32'd0 && result.height_tenths == 32'sd0))
        else $error("failed parse carries nonzero values");

endmodule

>>> hw/rtl/slp_out_buffer.sv
`timescale 1ns / 1ps

// Two-entry result buffer: output register plus skid register
module slp_out_buffer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  slp_pkg::result_t push_data,
    output logic             has_room,
    output logic             result_valid,
    input  logic             result_ready,
    output slp_pkg::result_t result
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    slp_pkg::result_t main_data_reg;
    slp_pkg::result_t skid_data_reg;
    logic             pop;

    assign pop          = main_valid_reg && result_ready;
    assign has_room     = !skid_valid_reg;
    assign result_valid = main_valid_reg;
    assign result       = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (push && (!main_valid_reg || pop))
            main_valid_reg <= 1'b1;
        else if (push)
            skid_valid_reg <= 1'b1;
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && (!main_valid_reg || pop))
            main_data_reg <= push_data;
        else if (push)
            skid_data_reg <= push_data;
        else if (pop && skid_valid_reg)
            main_data_reg <= skid_data_reg;
    end

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with output register empty");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into full buffer");

    a_skid_move: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved to output register");

endmodule

>>> hw/rtl/sensor_line_decimal_parser.sv
`timescale 1ns / 1ps

// Sensor text line parser: pressure and height as fixed-point tenths.
//
// Input channel (item_valid / item_ready / item): one ASCII byte per
// transaction, end_of_line set on the last byte of a line. Output channel
// (result_valid / result_ready / result): one transaction per line, holding
// pressure_tenths, height_tenths and parse_ok; values are zero when
// parse_ok is low.
//
// Throughput: one byte per cycle while item_ready is high. A line's result
// is registered (output or skid register) when its last byte is accepted.
// Bytes that do not end a line never produce a transaction.
//
// Stall: results sit in a two-entry buffer (output register plus skid).
// item_ready drops only while both entries hold untaken results; parsing
// of later bytes continues while one result waits.
//
// Reset (rst_n low, asynchronous): line state returns to the start of a
// line, the buffer empties, no result is pending.
module sensor_line_decimal_parser #(
    parameter int ACC_WIDTH = slp_pkg::ACC_WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  slp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output slp_pkg::result_t result
);

    logic             accept;
    logic             core_valid;
    slp_pkg::result_t core_result;
    logic             has_room;

    assign item_ready = has_room;
    assign accept     = item_valid && item_ready;

    // byte step logic and per-line state
    slp_parser_core #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (item),
        .result_valid (core_valid),
        .result       (core_result)
    );

    // result register with skid entry, decouples output stalls
    slp_out_buffer u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (core_valid),
        .push_data    (core_result),
        .has_room     (has_room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> tb/sv/slp_line_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts one result per line and compares.
module slp_line_checker
    import slp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_ready,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_ready,
    input  result_t result,
    input  logic    drain_done,
    output int      fault_count,
    output int      pending_lines,
    output int      lines_checked
);

    localparam int ACCW = ACC_WIDTH_DEFAULT;
    localparam logic [63:0] ACC_SAT = {64{1'b1}} >> (64 - ACCW);

    // predicted line state
    logic [63:0] acc;
    logic [1:0]  fields_done;
    logic        neg_height;
    logic        at_token_start;
    logic        tenths_due;
    logic        token_dirty;
    logic [31:0] pressure_q;
    logic [31:0] height_q;
    logic        line_clean;

    result_t expected_lines[$];
    logic    leftover_flagged;

    initial
    begin
        fault_count   = 0;
        lines_checked = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fault_count++;
    endtask

    function automatic logic [63:0] scale_add(input logic [63:0] v, input logic [63:0] d);
        if (v > (ACC_SAT - d) / 10)
            return ACC_SAT;
        return v * 10 + d;
    endfunction

    task automatic line_reset();
        acc            = '0;
        fields_done    = FIELD_PRESSURE;
        neg_height     = 1'b0;
        at_token_start = 1'b1;
        tenths_due     = 1'b0;
        token_dirty    = 1'b0;
        pressure_q     = '0;
        height_q       = '0;
        line_clean     = 1'b1;
    endtask

    task automatic open_new_token();
        acc            = '0;
        neg_height     = 1'b0;
        at_token_start = 1'b1;
        token_dirty    = 1'b0;
    endtask

    task automatic close_number(input logic [63:0] tenth);
        logic [63:0] v;
        v = scale_add(acc, tenth);
        if (fields_done == FIELD_PRESSURE)
            pressure_q = (v > PRESSURE_MAX) ? PRESSURE_MAX : v[31:0];
        else if (neg_height)
        begin
            if (v > HEIGHT_NEG_MAG)
                v = HEIGHT_NEG_MAG;
            height_q = 32'd0 - v[31:0];
        end
        else
        begin
            if (v > HEIGHT_POS_MAX)
                v = HEIGHT_POS_MAX;
            height_q = v[31:0];
        end
        fields_done = fields_done + 2'd1;
        tenths_due  = 1'b0;
    endtask

    task automatic parse_byte(input item_t it);
        logic [7:0] b;
        logic       is_digit;
        logic       ok;
        result_t    res;
        b        = it.rx_byte;
        is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        if (tenths_due)
        begin
            if (is_digit)
                close_number(64'(b - CHAR_ZERO));
            else
            begin
                line_clean = 1'b0;
                close_number(64'd0);
            end
            if (b == CHAR_SPACE)
                open_new_token();
            else
            begin
                token_dirty    = 1'b1;
                at_token_start = 1'b0;
            end
        end
        else if (b == CHAR_SPACE)
            open_new_token();
        else if (b == CHAR_DOT)
        begin
            if (fields_done < FIELD_DONE)
            begin
                if (token_dirty)
                    line_clean = 1'b0;
                tenths_due = 1'b1;
            end
            else
                token_dirty = 1'b1;
            at_token_start = 1'b0;
        end
        else if (b == CHAR_MINUS && at_token_start && fields_done == FIELD_HEIGHT)
        begin
            neg_height     = 1'b1;
            at_token_start = 1'b0;
        end
        else if (is_digit)
        begin
            acc            = scale_add(acc, 64'(b - CHAR_ZERO));
            at_token_start = 1'b0;
        end
        else
        begin
            token_dirty    = 1'b1;
            at_token_start = 1'b0;
        end

        if (it.end_of_line)
        begin
            ok = line_clean && (fields_done == FIELD_DONE) && !tenths_due;
            res.pressure_tenths = ok ? pressure_q : '0;
            res.height_tenths   = ok ? height_q : '0;
            res.parse_ok        = ok;
            expected_lines.push_back(res);
            line_reset();
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_lines.size() == 0)
            report_mismatch($sformatf("result transaction with nothing pending: %p", got));
        else
        begin
            want = expected_lines.pop_front();
            lines_checked++;
            if (got.pressure_tenths !== want.pressure_tenths)
                report_mismatch($sformatf("pressure_tenths %0d, want %0d",
                                          got.pressure_tenths, want.pressure_tenths));
            if (got.height_tenths !== want.height_tenths)
                report_mismatch($sformatf("height_tenths %0d, want %0d",
                                          got.height_tenths, want.height_tenths));
            if (got.parse_ok !== want.parse_ok)
                report_mismatch($sformatf("parse_ok %b, want %b",
                                          got.parse_ok, want.parse_ok));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reset();
            expected_lines.delete();
            leftover_flagged = 1'b0;
            pending_lines <= 0;
        end
        else
        begin
            // results are registered, so a result never belongs to a byte taken at the same edge
            if (result_valid && result_ready)
                check_result(result);
            if (item_valid && item_ready)
                parse_byte(item);
            if (drain_done && !leftover_flagged && expected_lines.size() != 0)
            begin
                report_mismatch($sformatf("%0d expected results never arrived",
                                          expected_lines.size()));
                leftover_flagged = 1'b1;
            end
            pending_lines <= expected_lines.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

// Top of the parser bench: makes clock, reset and byte stimulus, drives the
// result-side stall, and prints the verdict. All prediction and comparison
// lives in slp_line_checker.
module tb;
    import slp_pkg::*;

    localparam int TARGET_BYTES = 850;   // rough total of bytes sent, directed lines included
    localparam int DRAIN_LIMIT  = 5000;  // cycles allowed for the last results

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    logic    drain_done = 1'b0;

    int fault_count;
    int pending_lines;
    int lines_checked;

    // idling knobs, changed per phase (percent of cycles)
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int bytes_sent = 0;
    int lines_sent = 0;

    // bytes of the line being built
    logic [7:0] line_buf[$];

    always #5 clk = ~clk;

    sensor_line_decimal_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    slp_line_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .drain_done    (drain_done),
        .fault_count   (fault_count),
        .pending_lines (pending_lines),
        .lines_checked (lines_checked)
    );

    // Result-side backpressure: one fresh draw per cycle.
    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Hard stop in case the handshake locks up.
    initial
    begin
        #2_000_000;
        $display("timeout: result channel or byte channel stuck");
        $display("DONE: errors detected");
        $finish;
    end

    // One byte transaction. Idle gaps drop valid first, then valid rises and
    // stays up until the byte is taken.
    task automatic send_byte(input logic [7:0] b, input logic eol);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= {b, eol};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // Ships the buffered line, end_of_line on its last byte.
    task automatic send_line();
        int n;
        n = line_buf.size();
        for (int i = 0; i < n; i++)
            send_byte(line_buf[i], i == n - 1);
        line_buf.delete();
        bytes_sent += n;
        lines_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic add_digits(input int n);
        repeat (n)
            line_buf.push_back(8'(CHAR_ZERO + $urandom_range(9)));
    endtask

    // lowercase label such as a unit or a field tag
    task automatic add_word();
        repeat ($urandom_range(1, 4))
            line_buf.push_back(8'($urandom_range(97, 122)));
    endtask

    // One "[-]digits.d" number. Picks include the saturation edges, long
    // overflowing runs and an empty integer part.
    task automatic add_number(input logic height_field);
        int pick;
        int tenth_lo;
        pick     = $urandom_range(99);
        tenth_lo = 0;
        if (height_field && $urandom_range(1))
            line_buf.push_back(CHAR_MINUS);
        if (pick < 6)
        begin
            // 214748364.7/.8 and 429496729.5/.6 sit right on the clamp points
            push_text(height_field ? "214748364" : "429496729");
            tenth_lo = height_field ? 7 : 5;
        end
        else if (pick < 14)
            add_digits($urandom_range(10, 12));
        else if (pick < 22)
            ;  // empty integer part
        else
            add_digits($urandom_range(1, 5));
        line_buf.push_back(CHAR_DOT);
        line_buf.push_back(8'(CHAR_ZERO + $urandom_range(tenth_lo, 9)));
    endtask

    // Mostly well-formed sensor lines with random content; some get one
    // byte smashed or are cut short, and a few are pure noise.
    task automatic build_random_line();
        int kind;
        int keep;
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 10))
                line_buf.push_back(8'($urandom_range(255)));
        end
        else
        begin
            if ($urandom_range(1))
            begin
                add_word();
                line_buf.push_back(CHAR_SPACE);
            end
            add_number(1'b0);
            repeat ($urandom_range(1, 2))
                line_buf.push_back(CHAR_SPACE);
            if ($urandom_range(3) == 0)
            begin
                add_word();
                line_buf.push_back(CHAR_SPACE);
            end
            add_number(1'b1);
            case ($urandom_range(3))
                0: ;
                1: add_word();                   // unit glued to the number
                2:
                begin
                    line_buf.push_back(CHAR_SPACE);
                    add_word();
                end
                default:
                begin
                    line_buf.push_back(CHAR_SPACE);
                    add_number(1'b0);            // third number, its dot is ignored
                end
            endcase
            if (kind < 30)
            begin
                if ($urandom_range(1))
                    line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(255));
                else
                begin
                    keep = $urandom_range(1, line_buf.size() - 1);
                    while (line_buf.size() > keep)
                        void'(line_buf.pop_back());
                end
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines, no idling.
        line_buf.push_back(8'hFF);   // top byte value, line ends before any number
        send_line();
        line_buf.push_back(8'h00);   // bottom byte value
        send_line();
        push_text("1.2 -.4 5.6");    // clean line, empty integer part, ignored third dot
        send_line();
        push_text("x7.1 8.z");       // letter inside a number, bad tenths byte
        send_line();
        push_text("4.5q.3");         // text after a number before a second dot
        send_line();

        // Random part in four idling phases.
        while (bytes_sent < TARGET_BYTES)
        begin
            case (bytes_sent * 4 / TARGET_BYTES)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct  = 23;
                    recv_stall_pct = 23;
                end
            endcase
            build_random_line();
            send_line();
        end
        item_valid <= 1'b0;

        // Let the remaining results drain, bounded.
        for (int i = 0; i < DRAIN_LIMIT && pending_lines != 0; i++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        drain_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Summary: %0d lines, %0d bytes sent through four idling phases",
                 lines_sent, bytes_sent);
        $display("Summary: %0d result transactions compared, %0d mismatches",
                 lines_checked, fault_count);
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
